// ----- design/world_to_screen_projection_core_defines.svh -----
// ----------------------------------------------------------------------------
// World-to-screen projection core: assertion macros
// Shared property macros, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// General property on the block clock.
`define WTSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Same-cycle implication on the block clock.
`define WTSP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define WTSP_ASSERT(lbl, prop, msg)
`define WTSP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- design/wtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Opcodes, register indexes, reset values and the sideband carried
// alongside the divider.
// ----------------------------------------------------------------------------
package wtsp_pkg;

    // Item kinds carried in tuser.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_VIEW_WIDTH  = 1'b0;
    localparam logic CFG_VIEW_HEIGHT = 1'b1;

    localparam int VIEW_W = 14;
    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = 14'd1920;
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = 14'd1080;

    localparam int COEF_N = 16;

    // Per-item flags that travel with the divider lanes.
    typedef struct packed {
        logic visible;
        logic neg_x;
        logic neg_y;
    } t_side;

endpackage

// ----- design/wtsp_div.sv -----
// ----------------------------------------------------------------------------
// Two-lane pipelined fixed-point divider
// Computes floor(num * 2^FRAC_BITS / den) for two numerators over one
// shared denominator, one quotient bit per step stage, with overflow flags.
// ----------------------------------------------------------------------------
module wtsp_div
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int W         = 50
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_num_x,
    input  logic [W-1:0] i_num_y,
    input  logic [W-1:0] i_den,
    input  t_side        i_side,
    output logic         o_valid,
    output logic [31:0]  o_q_x,
    output logic [31:0]  o_q_y,
    output logic         o_ovf_x,
    output logic         o_ovf_y,
    output t_side        o_side
);

    localparam int STEPS = 32;
    localparam int HI_SH = 32 - FRAC_BITS;
    localparam int OV_SH = 31 - FRAC_BITS;

    logic         r_valid [0:STEPS];
    logic [W-1:0] r_rem_x [0:STEPS];
    logic [W-1:0] r_rem_y [0:STEPS];
    logic [31:0]  r_low_x [0:STEPS];
    logic [31:0]  r_low_y [0:STEPS];
    logic [31:0]  r_q_x   [0:STEPS];
    logic [31:0]  r_q_y   [0:STEPS];
    logic [W-1:0] r_den   [0:STEPS];
    logic         r_ovf_x [0:STEPS];
    logic         r_ovf_y [0:STEPS];
    t_side        r_side  [0:STEPS];

    logic [W-1:0] n_hi_x;
    logic [W-1:0] n_hi_y;

    // The remainder starts at num >> (32 - FRAC_BITS). The quotient does not
    // fit a signed 32-bit magnitude exactly when num >> (31 - FRAC_BITS) >= den.
    assign n_hi_x = i_num_x >> HI_SH;
    assign n_hi_y = i_num_y >> HI_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    // Entry stage: start the remainder at the high part of the numerator.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x[0] <= n_hi_x;
            r_rem_y[0] <= n_hi_y;
            r_low_x[0] <= {i_num_x[HI_SH-1:0], {FRAC_BITS{1'b0}}};
            r_low_y[0] <= {i_num_y[HI_SH-1:0], {FRAC_BITS{1'b0}}};
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_den[0]   <= i_den;
            r_ovf_x[0] <= ((i_num_x >> OV_SH) >= i_den);
            r_ovf_y[0] <= ((i_num_y >> OV_SH) >= i_den);
            r_side[0]  <= i_side;
        end
    end

    // One restoring step per stage for each lane.
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [W:0] n_sh_x;
        logic [W:0] n_sh_y;
        logic       n_bit_x;
        logic       n_bit_y;

        assign n_sh_x  = {r_rem_x[k-1], r_low_x[k-1][31]};
        assign n_sh_y  = {r_rem_y[k-1], r_low_y[k-1][31]};
        assign n_bit_x = (n_sh_x >= {1'b0, r_den[k-1]});
        assign n_bit_y = (n_sh_y >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[k] <= n_bit_x ? W'(n_sh_x - {1'b0, r_den[k-1]}) : W'(n_sh_x);
                r_rem_y[k] <= n_bit_y ? W'(n_sh_y - {1'b0, r_den[k-1]}) : W'(n_sh_y);
                r_low_x[k] <= {r_low_x[k-1][30:0], 1'b0};
                r_low_y[k] <= {r_low_y[k-1][30:0], 1'b0};
                r_q_x[k]   <= {r_q_x[k-1][30:0], n_bit_x};
                r_q_y[k]   <= {r_q_y[k-1][30:0], n_bit_y};
                r_den[k]   <= r_den[k-1];
                r_ovf_x[k] <= r_ovf_x[k-1];
                r_ovf_y[k] <= r_ovf_y[k-1];
                r_side[k]  <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_q_x   = r_q_x[STEPS];
    assign o_q_y   = r_q_y[STEPS];
    assign o_ovf_x = r_ovf_x[STEPS];
    assign o_ovf_y = r_ovf_y[STEPS];
    assign o_side  = r_side[STEPS];

endmodule

// ----- design/world_to_screen_projection_core.sv -----
// ----------------------------------------------------------------------------
// World-to-screen projection core
// Loads a 4x4 view-projection matrix item by item and projects world points
// to viewport coordinates in signed fixed point.
// ----------------------------------------------------------------------------
// The core takes one item per clock unless the output stalls. From input to
// output register it runs: input, products, row sums, magnitude and w check,
// 33 divider stages (an entry stage, then one quotient bit per stage), sign
// restore, viewport multiply and output. Coefficient loads write the bank at
// acceptance and produce no result; a project item right after a load already
// sees it. A stall at the output holds the whole pipeline. Rejected points
// come out with tuser low and zero coordinates. view_width and view_height
// may only change while no item is in flight.
`include "world_to_screen_projection_core_defines.svh"

module world_to_screen_projection_core
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [VIEW_W-1:0] i_cfg_data,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // coef_index[3:0], coef_value[35:4], world_x[67:36], world_y[99:68],
    // world_z[131:100], zero pad[135:132]
    input  logic [135:0]      s_axis_tdata,
    // opcode[0]
    input  logic [0:0]        s_axis_tuser,
    // Output stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // screen_x[31:0], screen_y[63:32]
    output logic [63:0]       m_axis_tdata,
    // visible[0]
    output logic [0:0]        m_axis_tuser
);

    localparam int PW    = 64 - FRAC_BITS;   // shifted product
    localparam int ACC_W = 66 - FRAC_BITS;   // row sum
    localparam int HW_W  = VIEW_W - 1;
    localparam int MW    = HW_W + 1 + 32;    // viewport product
    localparam int SUM_W = MW + 2;
    localparam logic signed [ACC_W-1:0] W_MIN =
        ACC_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

    logic en;
    logic in_acc;

    logic [VIEW_W-1:0]  r_view_width;
    logic [VIEW_W-1:0]  r_view_height;
    logic signed [31:0] r_bank [0:COEF_N-1];

    logic               r_s0_valid;
    logic signed [31:0] r_s0_x, r_s0_y, r_s0_z;

    logic               r_s1_valid;
    logic signed [PW-1:0] r_s1_p [0:8];
    logic signed [31:0] r_s1_c [0:2];

    logic               r_s2_valid;
    logic signed [ACC_W-1:0] r_s2_cx, r_s2_cy, r_s2_cw;

    logic               r_s3_valid;
    logic [ACC_W-1:0]   r_s3_ax, r_s3_ay, r_s3_d;
    t_side              r_s3_side;

    logic               d_valid;
    logic [31:0]        d_q_x, d_q_y;
    logic               d_ovf_x, d_ovf_y;
    t_side              d_side;

    logic               r_s4_valid;
    logic signed [31:0] r_s4_nx, r_s4_ny;
    logic               r_s4_vis;

    logic               r_s5_valid;
    logic signed [MW-1:0] r_s5_px, r_s5_py;
    logic               r_s5_vis;

    logic               r_out_valid;
    logic [31:0]        r_out_x, r_out_y;
    logic               r_out_vis;

    logic [HW_W-1:0]    hw, hh;

    // The pipeline moves whenever the output register can take a new item.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;

    assign hw = r_view_width[VIEW_W-1:1];
    assign hh = r_view_height[VIEW_W-1:1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_width  <= VIEW_WIDTH_RST;
            r_view_height <= VIEW_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VIEW_WIDTH:  r_view_width  <= i_cfg_data;
                CFG_VIEW_HEIGHT: r_view_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficient bank, written by load items at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEF_N; i++) begin
                r_bank[i] <= '0;
            end
        end else if (in_acc && s_axis_tuser[0] == OP_LOAD) begin
            r_bank[s_axis_tdata[3:0]] <= s_axis_tdata[35:4];
        end
    end

    // Valid bits of the front and back stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid  <= in_acc && s_axis_tuser[0] == OP_PROJECT;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= d_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    // Input register for the world point.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x <= s_axis_tdata[67:36];
            r_s0_y <= s_axis_tdata[99:68];
            r_s0_z <= s_axis_tdata[131:100];
        end
    end

    // Nine products of rows 0, 1 and 3, each shifted down rounding toward minus infinity.
    for (genvar r = 0; r < 3; r++) begin : g_row
        localparam int ROW = (r == 2) ? 3 : r;
        logic signed [63:0] n_px, n_py, n_pz;

        assign n_px = r_bank[ROW*4+0] * r_s0_x;
        assign n_py = r_bank[ROW*4+1] * r_s0_y;
        assign n_pz = r_bank[ROW*4+2] * r_s0_z;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s1_p[r*3+0] <= n_px[63:FRAC_BITS];
                r_s1_p[r*3+1] <= n_py[63:FRAC_BITS];
                r_s1_p[r*3+2] <= n_pz[63:FRAC_BITS];
                r_s1_c[r]     <= r_bank[ROW*4+3];
            end
        end
    end

    // Row sums: clip x, clip y and clip w.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_cx <= ACC_W'(r_s1_c[0]) + ACC_W'(r_s1_p[0]) + ACC_W'(r_s1_p[1])
                     + ACC_W'(r_s1_p[2]);
            r_s2_cy <= ACC_W'(r_s1_c[1]) + ACC_W'(r_s1_p[3]) + ACC_W'(r_s1_p[4])
                     + ACC_W'(r_s1_p[5]);
            r_s2_cw <= ACC_W'(r_s1_c[2]) + ACC_W'(r_s1_p[6]) + ACC_W'(r_s1_p[7])
                     + ACC_W'(r_s1_p[8]);
        end
    end

    // Visibility check and numerator magnitudes.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ax           <= r_s2_cx[ACC_W-1] ? ACC_W'(-r_s2_cx) : ACC_W'(r_s2_cx);
            r_s3_ay           <= r_s2_cy[ACC_W-1] ? ACC_W'(-r_s2_cy) : ACC_W'(r_s2_cy);
            r_s3_d            <= r_s2_cw;
            r_s3_side.visible <= (r_s2_cw >= W_MIN);
            r_s3_side.neg_x   <= r_s2_cx[ACC_W-1];
            r_s3_side.neg_y   <= r_s2_cy[ACC_W-1];
        end
    end

    wtsp_div #(
        .FRAC_BITS (FRAC_BITS),
        .W         (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_valid),
        .i_num_x (r_s3_ax),
        .i_num_y (r_s3_ay),
        .i_den   (r_s3_d),
        .i_side  (r_s3_side),
        .o_valid (d_valid),
        .o_q_x   (d_q_x),
        .o_q_y   (d_q_y),
        .o_ovf_x (d_ovf_x),
        .o_ovf_y (d_ovf_y),
        .o_side  (d_side)
    );

    // Restore the signs and saturate the normalized coordinates.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d_ovf_x) begin
                r_s4_nx <= d_side.neg_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_s4_nx <= d_side.neg_x ? -$signed(d_q_x) : $signed(d_q_x);
            end
            if (d_ovf_y) begin
                r_s4_ny <= d_side.neg_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_s4_ny <= d_side.neg_y ? -$signed(d_q_y) : $signed(d_q_y);
            end
            r_s4_vis <= d_side.visible;
        end
    end

    // Scale by the half viewport.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_px  <= $signed({1'b0, hw}) * r_s4_nx;
            r_s5_py  <= $signed({1'b0, hh}) * r_s4_ny;
            r_s5_vis <= r_s4_vis;
        end
    end

    // Offset to the viewport center and saturate to 32 bits.
    logic signed [SUM_W-1:0] n_sx, n_sy;

    assign n_sx = $signed(SUM_W'(hw) << FRAC_BITS) + SUM_W'(r_s5_px);
    assign n_sy = $signed(SUM_W'(hh) << FRAC_BITS) - SUM_W'(r_s5_py);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vis <= r_s5_vis;
            if (!r_s5_vis) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else begin
                r_out_x <= (n_sx > SAT_MAX) ? 32'h7FFF_FFFF :
                           (n_sx < SAT_MIN) ? 32'h8000_0000 : n_sx[31:0];
                r_out_y <= (n_sy > SAT_MAX) ? 32'h7FFF_FFFF :
                           (n_sy < SAT_MIN) ? 32'h8000_0000 : n_sy[31:0];
            end
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out_y, r_out_x};
    assign m_axis_tuser[0] = r_out_vis;

    // A rejected point always leaves with zero coordinates.
    `WTSP_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 64'd0, "rejected point with nonzero coordinates")
    // A load item never starts a result.
    `WTSP_ASSERT(a_load_no_token, (in_acc && s_axis_tuser[0] == OP_LOAD) |=> !r_s0_valid, "load item entered the pipeline")
    // A load lands in the bank entry it names.
    `WTSP_ASSERT(a_bank_write, (in_acc && s_axis_tuser[0] == OP_LOAD) |=> (r_bank[$past(s_axis_tdata[3:0])] == $past(s_axis_tdata[35:4])), "coefficient not stored")

endmodule
